@@ rtl/sci_pkg.sv @@
package sci_pkg;

	// Default coordinate width and matching index width
	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned INDEX_BITS_DEF = 2 * COORD_BITS_DEF + 1;

	// Reset value of the grid maximum: all ones at the default width
	localparam logic [COORD_BITS_DEF-1:0] GRID_MAX_RST = {COORD_BITS_DEF{1'b1}};

endpackage

@@ rtl/sci_front.sv @@
module sci_front
	import sci_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [COORD_BITS-1:0]   in_x,
	input  logic [COORD_BITS-1:0]   in_y,
	input  logic [COORD_BITS-1:0]   grid_max,
	output logic                    out_valid,
	output logic [COORD_BITS-1:0]   out_x,
	output logic [COORD_BITS-1:0]   out_y,
	output logic [2*COORD_BITS:0]   out_acc
);

	localparam int unsigned IW = 2 * COORD_BITS + 1;

	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic                  valid_s2;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] y_s2;
	logic                  swap_s2;
	logic                  swap_c;

	// Track request valid through both front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Clamp coordinates to the grid maximum
	always_ff @(posedge clk) begin
		x_s1 <= (in_x > grid_max) ? grid_max : in_x;
		y_s1 <= (in_y > grid_max) ? grid_max : in_y;
	end

	// Reflect through the grid maximum when x lies above y
	assign swap_c = x_s1 > y_s1;

	always_ff @(posedge clk) begin
		swap_s2 <= swap_c;
		x_s2    <= swap_c ? grid_max - x_s1 : x_s1;
		y_s2    <= swap_c ? grid_max - y_s1 : y_s1;
	end

	assign out_valid = valid_s2;
	assign out_x     = x_s2;
	assign out_y     = y_s2;
	assign out_acc   = {{(IW-1){1'b0}}, swap_s2};

endmodule

@@ rtl/sci_step.sv @@
module sci_step
	import sci_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned STEP       = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [COORD_BITS-1:0]   in_x,
	input  logic [COORD_BITS-1:0]   in_y,
	input  logic [2*COORD_BITS:0]   in_acc,
	input  logic [COORD_BITS-1:0]   grid_max,
	output logic                    out_valid,
	output logic [COORD_BITS-1:0]   out_x,
	output logic [COORD_BITS-1:0]   out_y,
	output logic [2*COORD_BITS:0]   out_acc
);

	localparam int unsigned IW = 2 * COORD_BITS + 1;

	logic                  active_c;
	logic [COORD_BITS:0]   max_w;
	logic [COORD_BITS:0]   sum_c;
	logic                  rot_c;
	logic [COORD_BITS:0]   dbl_x_c;
	logic [COORD_BITS:0]   dbl_y_c;
	logic [COORD_BITS:0]   rdbl_x_c;
	logic [COORD_BITS:0]   y2m_c;
	logic [COORD_BITS:0]   m2x_c;
	logic [COORD_BITS:0]   x2m_c;
	logic                  refl_n_c;
	logic                  refl_r_c;
	logic                  refl_c;
	logic [COORD_BITS:0]   xn_c;
	logic [COORD_BITS:0]   yn_c;

	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [IW-1:0]         acc_s1;

	// Step runs only while the grid maximum still has bits at or above it
	assign active_c = |grid_max[COORD_BITS-1:STEP];
	assign max_w    = {1'b0, grid_max};

	// Rotate when x + y exceeds the maximum
	assign sum_c = {1'b0, in_x} + {1'b0, in_y};
	assign rot_c = sum_c > max_w;

	// Build every doubled candidate in parallel with the rotation test
	assign dbl_x_c  = {in_x, 1'b0};
	assign dbl_y_c  = {in_y, 1'b0};
	assign rdbl_x_c = {grid_max - in_y, 1'b0};
	assign y2m_c    = dbl_y_c - max_w;
	assign m2x_c    = max_w - dbl_x_c;
	assign x2m_c    = dbl_x_c - max_w;

	// Reflect-shift when the doubled y exceeds the maximum; after a rotation y is the old x
	assign refl_n_c = dbl_y_c > max_w;
	assign refl_r_c = dbl_x_c > max_w;
	assign refl_c   = rot_c ? refl_r_c : refl_n_c;

	// Pick the next point from the two fold decisions
	always_comb begin
		case ({rot_c, refl_c})
			2'b00: begin
				xn_c = dbl_x_c;
				yn_c = dbl_y_c;
			end
			2'b01: begin
				xn_c = y2m_c;
				yn_c = m2x_c;
			end
			2'b10: begin
				xn_c = rdbl_x_c;
				yn_c = dbl_x_c;
			end
			default: begin
				xn_c = x2m_c;
				yn_c = y2m_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Advance the point and append two index bits, or pass through
	always_ff @(posedge clk) begin
		if (active_c) begin
			x_s1   <= xn_c[COORD_BITS-1:0];
			y_s1   <= yn_c[COORD_BITS-1:0];
			acc_s1 <= {in_acc[IW-3:0], rot_c, refl_c};
		end else begin
			x_s1   <= in_x;
			y_s1   <= in_y;
			acc_s1 <= in_acc;
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_acc   = acc_s1;

endmodule

@@ rtl/sierpinski_curve_index.sv @@
// Channel   | Signals                        | Transfer rule
// ----------+--------------------------------+------------------------------------
// request   | start, busy, coord_x, coord_y  | taken at clk edge with start && !busy
// result    | done, curve_index              | valid for the one cycle done is high
// config    | cfg_we, cfg_data               | grid_max written at edge with cfg_we
//
// One request enters every cycle; busy is held low since nothing stalls.
// The pipeline has two front stages (clamp, reflect) and one stage per
// refinement step, each holding one add, three compares and four subtracts.
// Reset clears all stage valid bits and sets grid_max to all ones.
// The receiver cannot stall; results leave in request order.
module sierpinski_curve_index
	import sci_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   coord_x,
	input  logic [COORD_BITS-1:0]   coord_y,
	output logic                    done,
	output logic [2*COORD_BITS:0]   curve_index,
	input  logic                    cfg_we,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	localparam int unsigned IW = 2 * COORD_BITS + 1;

	logic [COORD_BITS-1:0] grid_max_q;
	logic                  accept;

	logic                  vld   [0:COORD_BITS];
	logic [COORD_BITS-1:0] px    [0:COORD_BITS];
	logic [COORD_BITS-1:0] py    [0:COORD_BITS];
	logic [IW-1:0]         pacc  [0:COORD_BITS];

	// Hold the grid maximum; reset to all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_max_q <= {COORD_BITS{1'b1}};
		end else if (cfg_we) begin
			grid_max_q <= cfg_data;
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	sci_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_x      (coord_x),
		.in_y      (coord_y),
		.grid_max  (grid_max_q),
		.out_valid (vld[0]),
		.out_x     (px[0]),
		.out_y     (py[0]),
		.out_acc   (pacc[0])
	);

	// One stage per refinement step
	for (genvar k = 0; k < COORD_BITS; k++) begin : g_step
		sci_step #(
			.COORD_BITS (COORD_BITS),
			.STEP       (k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k]),
			.in_x      (px[k]),
			.in_y      (py[k]),
			.in_acc    (pacc[k]),
			.grid_max  (grid_max_q),
			.out_valid (vld[k+1]),
			.out_x     (px[k+1]),
			.out_y     (py[k+1]),
			.out_acc   (pacc[k+1])
		);
	end

	assign done        = vld[COORD_BITS];
	assign curve_index = pacc[COORD_BITS];

endmodule

@@ rtl/sci_checker.sv @@
module sci_checker
	import sci_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [COORD_BITS-1:0]   coord_x,
	input  logic [COORD_BITS-1:0]   coord_y,
	input  logic                    done,
	input  logic [2*COORD_BITS:0]   curve_index,
	input  logic                    cfg_we,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	localparam int unsigned LAT = COORD_BITS + 2;

	// Every accepted request yields a result
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request without result");

	// No result appears without a matching request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without request");

	// The origin always maps to index zero
	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(coord_x == '0 && coord_y == '0 && !cfg_we, LAT))
			|-> (curve_index == '0))
		else $error("origin gave nonzero index");

endmodule

bind sierpinski_curve_index sci_checker #(
	.COORD_BITS (COORD_BITS)
) u_sci_checker (.*);

@@ dv/tb_sierpinski_curve_index.sv @@
`timescale 1ns / 100ps

module tb_sierpinski_curve_index;
	import sci_pkg::*;

	localparam int unsigned CW = COORD_BITS_DEF;
	localparam int unsigned IW = INDEX_BITS_DEF;
	localparam logic [CW-1:0] MAX_COORD = {CW{1'b1}};
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = CW + 4;
	localparam int TAIL_CYCLES = 2 * (CW + 2);
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES = 8;
	localparam int REQUESTS_PER_PHASE = 240;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [IW-1:0] index;
	} curve_request_t;

	// Predict curve positions and match them against the block's results
	class curve_scoreboard;
		logic [CW-1:0] grid_max;
		curve_request_t expected_index[$];
		int unsigned fail_count;

		function new();
			grid_max = GRID_MAX_RST;
			fail_count = 0;
		endfunction

		function void set_grid_max(logic [CW-1:0] m);
			grid_max = m;
		endfunction

		function int pending();
			return expected_index.size();
		endfunction

		// Walk the fold tests once per bit of the grid maximum
		function logic [IW-1:0] sierpinski_index(logic [CW-1:0] x_in, logic [CW-1:0] y_in);
			logic [63:0] m, x, y, t, acc, span;
			m = grid_max;
			x = (x_in > grid_max) ? grid_max : x_in;
			y = (y_in > grid_max) ? grid_max : y_in;
			acc = 0;
			span = m;
			// Reflect points below the diagonal into the upper half
			if (x > y) begin
				acc = 1;
				x = m - x;
				y = m - y;
			end
			while (span != 0) begin
				acc = acc << 1;
				// Rotate when the point lies past the anti-diagonal
				if (x + y > m) begin
					t = x;
					acc[0] = 1'b1;
					x = m - y;
					y = t;
				end
				x = x << 1;
				y = y << 1;
				acc = acc << 1;
				// Reflect-shift when the doubled y leaves the grid
				if (y > m) begin
					t = x;
					acc[0] = 1'b1;
					x = y - m;
					y = m - t;
				end
				span = span >> 1;
			end
			return acc[IW-1:0];
		endfunction

		function void note_request(logic [CW-1:0] x, logic [CW-1:0] y);
			curve_request_t req;
			req.x = x;
			req.y = y;
			req.index = sierpinski_index(x, y);
			expected_index.push_back(req);
		endfunction

		function void check_result(logic [IW-1:0] got);
			curve_request_t req;
			if (expected_index.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result: curve_index %h", got);
				return;
			end
			req = expected_index.pop_front();
			if (got !== req.index) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("mismatch at x=%0d y=%0d grid_max=%0d: expected %h, got %h",
						req.x, req.y, grid_max, req.index, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [CW-1:0] coord_x;
	logic [CW-1:0] coord_y;
	logic done;
	logic [IW-1:0] curve_index;
	logic cfg_we;
	logic [CW-1:0] cfg_data;

	curve_scoreboard sb = new();
	int idle_cycles = 0;

	sierpinski_curve_index #(
		.COORD_BITS(CW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.done(done),
		.curve_index(curve_index),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Record requests and results at each edge; stop a stalled run
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(coord_x, coord_y);
			if (done)
				sb.check_result(curve_index);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Hold one request until the block takes it
	task automatic send_request(input logic [CW-1:0] x, input logic [CW-1:0] y);
		start <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drain the pipeline, then write the grid maximum
	task automatic write_grid_max(input logic [CW-1:0] m);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		sb.set_grid_max(m);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range points, with corners, clamp cases and tiny values mixed in
	function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] m);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CW'($urandom_range(0, m));
			6: return $urandom_range(0, 1) ? m : '0;
			7: return CW'($urandom);
			8: return CW'($urandom_range(m, MAX_COORD));
			default: return CW'($urandom_range(0, 3));
		endcase
	endfunction

	// Send random requests in bursts with random gaps
	task automatic run_phase(input int count, input logic [CW-1:0] m);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && sent < count) begin
				send_request(pick_coord(m), pick_coord(m));
				burst--;
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		logic [CW-1:0] m;
		start <= 1'b0;
		coord_x <= '0;
		coord_y <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners and halves at the reset grid maximum
		send_request('0, '0);
		send_request(MAX_COORD, MAX_COORD);
		send_request('0, MAX_COORD);
		send_request(MAX_COORD, '0);
		send_request(CW'(1), '0);
		send_request('0, CW'(1));
		send_request(CW'(16'h8000), CW'(16'h7FFF));
		send_request(CW'(16'h7FFF), CW'(16'h8000));
		send_request(CW'(16'hAAAA), CW'(16'h5555));
		send_request(CW'(16'h5555), CW'(16'hAAAA));
		start <= 1'b0;

		// Zero grid: no refinement, every coordinate clamps to zero
		write_grid_max('0);
		send_request('0, '0);
		send_request(MAX_COORD, MAX_COORD);
		send_request(CW'(5), '0);
		start <= 1'b0;

		// Coordinates at, just past and far past the grid maximum
		write_grid_max(CW'(1000));
		send_request(CW'(1000), CW'(1000));
		send_request(CW'(1001), '0);
		send_request('0, MAX_COORD);
		send_request(CW'(999), CW'(1000));
		send_request(CW'(500), CW'(499));
		send_request(MAX_COORD, CW'(3));
		start <= 1'b0;

		write_grid_max(CW'(1));
		send_request(CW'(1), '0);
		send_request('0, CW'(1));
		start <= 1'b0;

		// Random traffic over a spread of grid sizes
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: m = MAX_COORD;
				1: m = CW'(16'h8000);
				2: m = CW'(16'h7FFF);
				3: m = CW'($urandom_range(3, 255));
				4: m = '0;
				5: m = CW'($urandom_range(256, MAX_COORD));
				default: m = CW'($urandom);
			endcase
			write_grid_max(m);
			run_phase(REQUESTS_PER_PHASE, m);
		end

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sierpinski_curve_index.f @@
rtl/sci_pkg.sv
rtl/sci_front.sv
rtl/sci_step.sv
rtl/sierpinski_curve_index.sv
rtl/sci_checker.sv
dv/tb_sierpinski_curve_index.sv
